/* src/bdlp_pkg.sv */
// ----------------------------------------------------------------------------
// bdlp_pkg
// shared constants and types for the button debounce / long-press block
// ----------------------------------------------------------------------------
package bdlp_pkg;

    // timestamp width used for all elapsed-time arithmetic
    localparam int TIME_BITS_DEFAULT = 32;

    // register reset values
    localparam logic [15:0] DEBOUNCE_MS_RESET   = 16'd50;
    localparam logic [31:0] LONG_PRESS_MS_RESET = 32'd0;

    // apb
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register map, index is paddr[2]
    typedef enum logic
    {
        REG_DEBOUNCE_MS   = 1'b0,
        REG_LONG_PRESS_MS = 1'b1
    } reg_idx_t;

    // stream word widths, fields packed from bit 0 and padded to bytes
    localparam int IN_DATA_W  = 40; // sample_time, button_level, clear_count
    localparam int OUT_DATA_W = 72; // debounced, press_event, press_total,
                                    // long_press_event, held_ms

endpackage : bdlp_pkg

/* src/button_debounce_long_press.sv */
// ----------------------------------------------------------------------------
// button_debounce_long_press
// debounce filter with press counter and long-press detector
// ----------------------------------------------------------------------------
// Each input word carries one button sample: a wrapping millisecond timestamp,
// the raw pressed level and a flag that clears the press counter before this
// sample is counted. A four-state filter (released, pre-active, active,
// pre-release) only changes the debounced level once the raw level has held
// its new value for debounce_ms; even with debounce_ms at zero the pre state
// takes one sample. On the debounced press edge the block flags press_event,
// bumps a wrapping 32-bit press counter and arms a long-press timer; the first
// sample whose hold time reaches long_press_ms flags long_press_event once,
// with held_ms, and a debounced release disarms it. All elapsed times are
// taken modulo 2^TIME_BITS, so a timestamp running backwards looks like a very
// long interval. Throughput is one sample per clock, taken whenever the output
// register is empty or being drained in the same cycle; the whole update is one
// pass of compare and subtract logic from the state registers into the output
// register. Registers must be written over apb only while the stream is idle,
// a rule for the user that the block itself does not enforce: debounce_ms at
// 0x0 and long_press_ms at 0x4.
// ----------------------------------------------------------------------------
module button_debounce_long_press
#(
    parameter int TIME_BITS = bdlp_pkg::TIME_BITS_DEFAULT
)
(
    input  logic                             clk,
    input  logic                             rst_n,

    // apb register port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bdlp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bdlp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bdlp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,

    // sample stream in
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [31:0] sample_time, [32] button_level, [33] clear_count, rest zero
    input  logic [bdlp_pkg::IN_DATA_W-1:0]   s_tdata,

    // result stream out
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] debounced, [1] press_event, [33:2] press_total,
    // [34] long_press_event, [66:35] held_ms, rest zero
    output logic [bdlp_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import bdlp_pkg::*;

    // width wide enough to compare elapsed times against either register
    localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;

    typedef enum logic [1:0]
    {
        ST_RELEASED    = 2'd0,
        ST_PRE_ACTIVE  = 2'd1,
        ST_ACTIVE      = 2'd2,
        ST_PRE_RELEASE = 2'd3
    } filt_state_t;

    // configuration
    logic [15:0]          debounce_ms_reg;
    logic [31:0]          long_press_ms_reg;

    // filter and press tracking state
    filt_state_t          state_reg, state_next;
    logic [TIME_BITS-1:0] edge_time_reg, edge_time_next;
    logic [TIME_BITS-1:0] press_start_reg, press_start_next;
    logic                 long_armed_reg, long_armed_next;
    logic [31:0]          press_count_reg, press_count_next;

    // output register
    logic                 out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    // unpacked input word
    logic [TIME_BITS-1:0] now;
    logic                 level;
    logic                 clear;

    logic [TIME_BITS-1:0] edge_elapsed;
    logic                 debounce_done;
    logic                 deb, prev_deb, press_ev;
    logic [31:0]          count_base;
    logic                 armed_tmp;
    logic [TIME_BITS-1:0] held;
    logic                 long_ev;
    logic [31:0]          hold;

    logic                 cfg_write;
    logic                 in_take;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    // take a sample whenever the output register will be free
    assign s_tready  = ~out_valid_reg | m_tready;
    assign in_take   = s_tvalid & s_tready;

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // register readback
    always_comb
    begin
        unique case (reg_idx_t'(paddr[2]))
            REG_DEBOUNCE_MS:   prdata = {16'd0, debounce_ms_reg};
            REG_LONG_PRESS_MS: prdata = long_press_ms_reg;
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // per-sample update
    // ------------------------------------------------------------------
    assign now   = TIME_BITS'(s_tdata[31:0]);
    assign level = s_tdata[32];
    assign clear = s_tdata[33];

    // elapsed time since the last raw edge, modulo the timestamp width
    assign edge_elapsed  = now - edge_time_reg;
    assign debounce_done = edge_elapsed >= TIME_BITS'(debounce_ms_reg);

    always_comb
    begin
        state_next     = state_reg;
        edge_time_next = edge_time_reg;
        unique case (state_reg)
            ST_RELEASED:
            begin
                if (level)
                begin
                    edge_time_next = now;
                    state_next     = ST_PRE_ACTIVE;
                end
            end
            ST_PRE_ACTIVE:
            begin
                if (!level)
                    state_next = ST_RELEASED;
                else if (debounce_done)
                    state_next = ST_ACTIVE;
            end
            ST_ACTIVE:
            begin
                if (!level)
                begin
                    edge_time_next = now;
                    state_next     = ST_PRE_RELEASE;
                end
            end
            ST_PRE_RELEASE:
            begin
                if (level)
                    state_next = ST_ACTIVE;
                else if (debounce_done)
                    state_next = ST_RELEASED;
            end
            default:
            begin
                state_next = ST_RELEASED;
            end
        endcase
    end

    // debounced level before and after this sample
    assign prev_deb = (state_reg == ST_ACTIVE) || (state_reg == ST_PRE_RELEASE);
    assign deb      = (state_next == ST_ACTIVE) || (state_next == ST_PRE_RELEASE);
    assign press_ev = deb & ~prev_deb;

    // clear takes effect before the press is counted
    assign count_base       = clear ? 32'd0 : press_count_reg;
    assign press_count_next = press_ev ? count_base + 32'd1 : count_base;
    assign press_start_next = press_ev ? now : press_start_reg;

    // arm on the press edge, disarm on release
    assign armed_tmp = press_ev | (deb & long_armed_reg);

    assign held    = now - press_start_next;
    assign long_ev = armed_tmp & (CMP_W'(held) >= CMP_W'(long_press_ms_reg));
    assign hold    = long_ev ? 32'(held) : 32'd0;

    assign long_armed_next = armed_tmp & ~long_ev;

    assign out_data_next = {5'd0, hold, long_ev, press_count_next, press_ev, deb};

    // ------------------------------------------------------------------
    // state, configuration and output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms_reg   <= DEBOUNCE_MS_RESET;
            long_press_ms_reg <= LONG_PRESS_MS_RESET;
            state_reg         <= ST_RELEASED;
            edge_time_reg     <= '0;
            press_start_reg   <= '0;
            long_armed_reg    <= 1'b0;
            press_count_reg   <= '0;
            out_valid_reg     <= 1'b0;
            out_data_reg      <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (reg_idx_t'(paddr[2]))
                    REG_DEBOUNCE_MS:   debounce_ms_reg   <= pwdata[15:0];
                    REG_LONG_PRESS_MS: long_press_ms_reg <= pwdata;
                    default:           ;
                endcase
            end

            if (in_take)
            begin
                state_reg       <= state_next;
                edge_time_reg   <= edge_time_next;
                press_start_reg <= press_start_next;
                long_armed_reg  <= long_armed_next;
                press_count_reg <= press_count_next;
                out_data_reg    <= out_data_next;
                out_valid_reg   <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule : button_debounce_long_press

/* src/bdlp_checker.sv */
// ----------------------------------------------------------------------------
// bdlp_checker
// port-level checks for the button debounce / long-press block
// ----------------------------------------------------------------------------
module bdlp_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [bdlp_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import bdlp_pkg::*;

    // a press edge always leaves the debounced level high
    a_press_implies_deb: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1]) |-> m_tdata[0])
        else $error("press event without debounced level");

    // hold time only carries a value alongside a long-press event
    a_hold_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[34]) |-> (m_tdata[66:35] == 32'd0))
        else $error("hold time set without long-press event");

    // a stalled result blocks new samples
    a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("sample taken while result stalled");

    // an accepted sample shows up as a result on the next cycle
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted sample produced no result");

    // a stalled result holds its word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule : bdlp_checker

bind button_debounce_long_press bdlp_checker u_bdlp_checker (.*);

/* tb/button_debounce_long_press_test.sv */
// ----------------------------------------------------------------------------
// button_debounce_long_press_test
// self-checking bench for the debounce filter, press counter and long-press
// ----------------------------------------------------------------------------
// Button samples go in as stream words and every result word is compared
// with the bench's own model of the filter, counter and long-press timer.
// A short directed script covers reset behaviour, the debounce boundary,
// a release bounce, clear with press, timestamp wrap and a
// timestamp that runs backwards. Random phases with several register
// settings follow, with realistic press runs, some bounce and some time
// jumps. Both stream sides idle at random, except in one quiet phase.
// ----------------------------------------------------------------------------
module button_debounce_long_press_test;

    timeunit 1ns;
    timeprecision 1ps;

    import bdlp_pkg::*;

    // run length guard, far above the slowest legal run
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned PHASE_COUNT  = 8;
    localparam int unsigned PHASE_WORDS  = 125;
    // cycles left after the last expected word before touching registers
    localparam int unsigned SETTLE_CYCLES = 4;

    // debounce filter states, as the block sequences them
    typedef enum logic [1:0]
    {
        FLT_RELEASED    = 2'd0,
        FLT_PRE_ACTIVE  = 2'd1,
        FLT_ACTIVE      = 2'd2,
        FLT_PRE_RELEASE = 2'd3
    } filter_state_t;

    // one result word, unpacked
    typedef struct packed
    {
        logic        debounced;
        logic        press_event;
        logic [31:0] press_total;
        logic        long_press_event;
        logic [31:0] held_ms;
    } press_report_t;

    typedef enum logic
    {
        ROW_SAMPLE = 1'b0,
        ROW_WRITE  = 1'b1
    } row_kind_t;

    // one line of the directed script; value is the timestamp of a sample
    // row or the data of a register write row
    typedef struct packed
    {
        row_kind_t     kind;
        reg_idx_t      target;
        logic [31:0]   value;
        logic          level;
        logic          clear;
        logic          typed;
        press_report_t want;
    } script_row_t;

    // directed script, reset settings until the two writes near the end
    localparam script_row_t DIRECTED [0:25] = '{
        // idle after reset: nothing pressed, nothing counted
        '{ROW_SAMPLE, REG_DEBOUNCE_MS, 32'd0, 1'b0, 1'b0,
          1'b1, '{1'b0, 1'b0, 32'd0, 1'b0, 32'd0}},
        // press seen, filter waits
        '{ROW_SAMPLE, REG_DEBOUNCE_MS, 32'd10, 1'b1, 1'b0,
          1'b1, '{1'b0, 1'b0, 32'd0, 1'b0, 32'd0}},
        // one ms short of the debounce time
        '{ROW_SAMPLE, REG_DEBOUNCE_MS, 32'd59, 1'b1, 1'b0,
          1'b1, '{1'b0, 1'b0, 32'd0, 1'b0, 32'd0}},
        // debounce time reached: press edge and, with zero hold time, long press
        '{ROW_SAMPLE, REG_DEBOUNCE_MS, 32'd60, 1'b1, 1'b0,
          1'b1, '{1'b1, 1'b1, 32'd1, 1'b1, 32'd0}},
        // release bounce that comes back before it settles
        '{ROW_SAMPLE, REG_DEBOUNCE_MS, 32'd100, 1'b0, 1'b0,
          1'b1, '{1'b1, 1'b0, 32'd1, 1'b0, 32'd0}},
        '{ROW_SAMPLE, REG_DEBOUNCE_MS, 32'd120, 1'b1, 1'b0,
          1'b1, '{1'b1, 1'b0, 32'd1, 1'b0, 32'd0}},
        // a real release
        '{ROW_SAMPLE, REG_DEBOUNCE_MS, 32'd130, 1'b0, 1'b0,
          1'b1, '{1'b1, 1'b0, 32'd1, 1'b0, 32'd0}},
        '{ROW_SAMPLE, REG_DEBOUNCE_MS, 32'd180, 1'b0, 1'b0,
          1'b1, '{1'b0, 1'b0, 32'd1, 1'b0, 32'd0}},
        // clear on its own, then clear together with the press edge
        '{ROW_SAMPLE, REG_DEBOUNCE_MS, 32'd200, 1'b1, 1'b1,
          1'b1, '{1'b0, 1'b0, 32'd0, 1'b0, 32'd0}},
        '{ROW_SAMPLE, REG_DEBOUNCE_MS, 32'd250, 1'b1, 1'b1,
          1'b1, '{1'b1, 1'b1, 32'd1, 1'b1, 32'd0}},
        // release across the timestamp wrap
        '{ROW_SAMPLE, REG_DEBOUNCE_MS, 32'hFFFF_FFF0, 1'b1, 1'b0,
          1'b1, '{1'b1, 1'b0, 32'd1, 1'b0, 32'd0}},
        '{ROW_SAMPLE, REG_DEBOUNCE_MS, 32'hFFFF_FFF0, 1'b0, 1'b0,
          1'b1, '{1'b1, 1'b0, 32'd1, 1'b0, 32'd0}},
        '{ROW_SAMPLE, REG_DEBOUNCE_MS, 32'h0000_0021, 1'b0, 1'b0,
          1'b1, '{1'b1, 1'b0, 32'd1, 1'b0, 32'd0}},
        '{ROW_SAMPLE, REG_DEBOUNCE_MS, 32'h0000_0022, 1'b0, 1'b0,
          1'b1, '{1'b0, 1'b0, 32'd1, 1'b0, 32'd0}},
        // time running backwards reads as a very long wait
        '{ROW_SAMPLE, REG_DEBOUNCE_MS, 32'h0000_0100, 1'b1, 1'b0,
          1'b1, '{1'b0, 1'b0, 32'd1, 1'b0, 32'd0}},
        '{ROW_SAMPLE, REG_DEBOUNCE_MS, 32'h0000_0050, 1'b1, 1'b0,
          1'b1, '{1'b1, 1'b1, 32'd2, 1'b1, 32'd0}},
        // zero debounce and a real long-press threshold
        '{ROW_WRITE, REG_DEBOUNCE_MS, 32'hA5A5_0000, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_LONG_PRESS_MS, 32'd100, 1'b0, 1'b0, 1'b0, '0},
        // the pre-active state still takes one sample
        '{ROW_SAMPLE, REG_DEBOUNCE_MS, 32'd1000, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, REG_DEBOUNCE_MS, 32'd1000, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, REG_DEBOUNCE_MS, 32'd2000, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, REG_DEBOUNCE_MS, 32'd2000, 1'b1, 1'b0, 1'b0, '0},
        // hold just short of, then exactly at, the threshold; fires once only
        '{ROW_SAMPLE, REG_DEBOUNCE_MS, 32'd2099, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, REG_DEBOUNCE_MS, 32'd2100, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, REG_DEBOUNCE_MS, 32'd2300, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, REG_DEBOUNCE_MS, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, '0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic                  s_tvalid;
    logic                  s_tready;
    // [31:0] sample_time, [32] button_level, [33] clear_count, rest zero
    logic [IN_DATA_W-1:0]  s_tdata;

    logic                  m_tvalid;
    logic                  m_tready;
    // [0] debounced, [1] press_event, [33:2] press_total,
    // [34] long_press_event, [66:35] held_ms, rest zero
    logic [OUT_DATA_W-1:0] m_tdata;

    // reports still owed by the block, oldest first
    press_report_t pending_reports [$];
    int unsigned   fault_count = 0;
    int unsigned   cycle_count = 0;
    // chance in a hundred that a side idles in a given cycle
    int unsigned   idle_pct    = 12;

    // model copy of the registers and the block state, reset values
    logic [15:0]   debounce_cfg   = DEBOUNCE_MS_RESET;
    logic [31:0]   long_press_cfg = LONG_PRESS_MS_RESET;
    filter_state_t filter_now     = FLT_RELEASED;
    logic [31:0]   edge_stamp     = '0;
    logic [31:0]   press_stamp    = '0;
    logic          long_armed     = 1'b0;
    logic          was_debounced  = 1'b0;
    logic [31:0]   press_tally    = '0;

    button_debounce_long_press dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 clk = ~clk;

    // advances the model by one sample and returns the report it should give
    function automatic press_report_t predict_report(input logic [31:0] stamp,
                                                     input logic        level,
                                                     input logic        clear);
        press_report_t report;
        logic [31:0]   since_edge;
        logic [31:0]   held;
        report     = '0;
        since_edge = stamp - edge_stamp;
        // clear lands before any increment from this same sample
        if (clear)
            press_tally = '0;
        case (filter_now)
            FLT_RELEASED:
            begin
                if (level)
                begin
                    edge_stamp = stamp;
                    filter_now = FLT_PRE_ACTIVE;
                end
            end
            FLT_PRE_ACTIVE:
            begin
                if (!level)
                    filter_now = FLT_RELEASED;
                else if (since_edge >= {16'd0, debounce_cfg})
                    filter_now = FLT_ACTIVE;
            end
            FLT_ACTIVE:
            begin
                if (!level)
                begin
                    edge_stamp = stamp;
                    filter_now = FLT_PRE_RELEASE;
                end
            end
            default:
            begin
                if (level)
                    filter_now = FLT_ACTIVE;
                else if (since_edge >= {16'd0, debounce_cfg})
                    filter_now = FLT_RELEASED;
            end
        endcase
        report.debounced = (filter_now == FLT_ACTIVE) || (filter_now == FLT_PRE_RELEASE);
        // debounced rising edge: count it and arm the long-press timer
        if (report.debounced && !was_debounced)
        begin
            press_tally        = press_tally + 32'd1;
            press_stamp        = stamp;
            long_armed         = 1'b1;
            report.press_event = 1'b1;
        end
        else if (!report.debounced)
        begin
            long_armed = 1'b0;
        end
        was_debounced = report.debounced;
        // hold time wraps with the timestamp
        held = stamp - press_stamp;
        if (long_armed && held >= long_press_cfg)
        begin
            report.long_press_event = 1'b1;
            report.held_ms          = held;
            long_armed              = 1'b0;
        end
        report.press_total = press_tally;
        return report;
    endfunction

    // offers one sample word, with random idle cycles ahead of it
    task automatic send_sample(input logic [31:0]   stamp,
                               input logic          level,
                               input logic          clear,
                               input logic          typed,
                               input press_report_t want);
        press_report_t predicted;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, clear, level, stamp};
        do
            @(posedge clk);
        while (!s_tready);
        // word taken at this edge: the model steps in the same order
        predicted = predict_report(stamp, level, clear);
        pending_reports.push_back(typed ? want : predicted);
    endtask

    // stops the stream and waits until every owed report has come out
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb write, then a read back of the same register
    task automatic program_register(input reg_idx_t target, input logic [31:0] value);
        logic [31:0] stored;
        stored  = (target == REG_DEBOUNCE_MS) ? {16'd0, value[15:0]} : value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {target, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        // register takes the value at this edge
        if (target == REG_DEBOUNCE_MS)
            debounce_cfg = value[15:0];
        else
            long_press_cfg = value;
        // back to setup for the read
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== stored)
        begin
            $display("%0t: register %s read back, expected %h, got %h",
                     $realtime, target.name(), stored, prdata);
            fault_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // press runs of random length with random gaps between samples, some
    // bounce against the run's level, some clears and the odd time jump
    task automatic run_random_phase(input int unsigned words,
                                    input int unsigned step_max);
        logic [31:0] stamp;
        logic        intended;
        logic        level;
        logic        clear;
        int unsigned run_left;
        int unsigned k;
        stamp    = $urandom;
        intended = 1'($urandom_range(0, 1));
        run_left = 0;
        for (k = 0; k < words; k++)
        begin
            if (run_left == 0)
            begin
                intended = ~intended;
                run_left = $urandom_range(1, 40);
            end
            run_left--;
            // a jump of a random amount, often effectively backwards
            if ($urandom_range(0, 99) < 2)
                stamp = stamp + $urandom;
            else
                stamp = stamp + $urandom_range(0, step_max);
            level = ($urandom_range(0, 99) < 8) ? ~intended : intended;
            clear = ($urandom_range(0, 99) < 3);
            send_sample(stamp, level, clear, 1'b0, '0);
        end
    endtask

    // result side: random back-pressure and the comparison of each word
    always @(posedge clk)
    begin
        press_report_t got;
        press_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.debounced        = m_tdata[0];
            got.press_event      = m_tdata[1];
            got.press_total      = m_tdata[33:2];
            got.long_press_event = m_tdata[34];
            got.held_ms          = m_tdata[66:35];
            if (pending_reports.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, got deb=%0b press=%0b",
                         $realtime, got.debounced, got.press_event);
                $display("    total=%0d long=%0b hold=%0d",
                         got.press_total, got.long_press_event, got.held_ms);
                fault_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (got !== want)
                begin
                    $display("%0t: report mismatch", $realtime);
                    $display("    expected deb=%0b press=%0b total=%0d long=%0b hold=%0d",
                             want.debounced, want.press_event, want.press_total,
                             want.long_press_event, want.held_ms);
                    $display("    actual   deb=%0b press=%0b total=%0d long=%0b hold=%0d",
                             got.debounced, got.press_event, got.press_total,
                             got.long_press_event, got.held_ms);
                    fault_count++;
                end
            end
        end
        m_tready <= ($urandom_range(0, 99) >= idle_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] debounce_pick;
        logic [31:0] long_pick;
        int unsigned phase;

        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        m_tready <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed script; typed rows carry their own expected word
        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].kind == ROW_WRITE)
            begin
                wait_idle();
                program_register(DIRECTED[i].target, DIRECTED[i].value);
            end
            else
            begin
                send_sample(DIRECTED[i].value, DIRECTED[i].level, DIRECTED[i].clear,
                            DIRECTED[i].typed, DIRECTED[i].want);
            end
        end

        // random phases, each under its own register setting
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0:
                begin
                    // both registers at zero
                    debounce_pick = 16'd0;
                    long_pick     = 32'd0;
                end
                1:
                begin
                    // both registers at their top value
                    debounce_pick = 16'hFFFF;
                    long_pick     = 32'hFFFF_FFFF;
                end
                2:
                begin
                    debounce_pick = 16'd1;
                    long_pick     = 32'd1;
                end
                4:
                begin
                    debounce_pick = 16'hFFFF;
                    long_pick     = $urandom_range(0, 300000);
                end
                7:
                begin
                    debounce_pick = 16'($urandom);
                    long_pick     = $urandom;
                end
                default:
                begin
                    debounce_pick = 16'($urandom_range(0, 300));
                    long_pick     = $urandom_range(0, 4 * debounce_pick + 200);
                end
            endcase
            // one phase runs with no idling on either side
            idle_pct = (phase == 3) ? 0 : 12;
            wait_idle();
            // upper half of the debounce write is junk the block must drop
            program_register(REG_DEBOUNCE_MS, {16'($urandom), debounce_pick});
            program_register(REG_LONG_PRESS_MS, long_pick);
            run_random_phase(PHASE_WORDS, debounce_pick / 4 + 3);
        end

        wait_idle();
        if (fault_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule : button_debounce_long_press_test
